/* hw/rtl/rsfc_pkg.sv */
// Shared types and constants of the real-time-clock seconds/field converter.
// Holds the pipeline depth, time constants and reciprocal constants for the
// constant dividers. Depends on nothing.
`default_nettype none

package rsfc_pkg;

  localparam int DAY_BITS_DEF = 14;
  localparam int STAGES       = 7;

  localparam logic [31:0] BASE_RESET = 32'd1104537600;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 24 * 60 * 60;

  // The day field is limited to 14 bits regardless of the day range.
  localparam int DAY_FIELD_MASK = 'h3fff;

  localparam int SEC_W   = 33;
  localparam int HMS_W   = 17;
  localparam int REM_W   = 12;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int HALF_W  = 7;
  localparam int DAY_Q_W = 16;

  // Day quotient: offset / 86400 = (offset >> 7) / 675, by reciprocal.
  localparam int DAY_PRE_SHIFT   = 7;
  localparam int DAY_DIV         = SEC_PER_DAY >> DAY_PRE_SHIFT;
  localparam int DAY_RECIP_SHIFT = 35;
  localparam longint DAY_RECIP   =
    ((longint'(1) << DAY_RECIP_SHIFT) + DAY_DIV - 1) / DAY_DIV;
  localparam int DAY_X_W         = 32 - DAY_PRE_SHIFT;
  localparam int DAY_RECIP_W     = 26;
  localparam int DAY_PROD_W      = DAY_X_W + DAY_RECIP_W;

  // Hour quotient: hms / 3600 = (hms >> 4) / 225.
  localparam int HOUR_PRE_SHIFT   = 4;
  localparam int HOUR_DIV         = SEC_PER_HOUR >> HOUR_PRE_SHIFT;
  localparam int HOUR_RECIP_SHIFT = 21;
  localparam longint HOUR_RECIP   =
    ((longint'(1) << HOUR_RECIP_SHIFT) + HOUR_DIV - 1) / HOUR_DIV;
  localparam int HOUR_PROD_W      = 27;

  // Minute quotient: rem / 60 = (rem >> 2) / 15.
  localparam int MIN_PRE_SHIFT   = 2;
  localparam int MIN_DIV         = SEC_PER_MIN >> MIN_PRE_SHIFT;
  localparam int MIN_RECIP_SHIFT = 14;
  localparam longint MIN_RECIP   =
    ((longint'(1) << MIN_RECIP_SHIFT) + MIN_DIV - 1) / MIN_DIV;
  localparam int MIN_PROD_W      = 21;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BEFORE   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/rsfc_split.sv */
// Seven-stage split datapath: seconds minus base into day, hour, minute and
// half seconds using reciprocal multipliers. Depends on rsfc_pkg.
`default_nettype none

module rsfc_split import rsfc_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [31:0]         now_seconds,
  input  wire logic [31:0]         base_seconds,
  output status_t                  status,
  output logic     [DAY_BITS-1:0]  day,
  output logic     [HOUR_W-1:0]    hour,
  output logic     [MIN_W-1:0]     minute,
  output logic     [HALF_W-1:0]    half_second
);

  // Stage A
  logic [31:0]          off_a_r;
  logic                 bef_a_r;
  // Stage B
  logic [31:0]          off_b_r;
  logic                 bef_b_r;
  logic [DAY_Q_W-1:0]   q_b_r;
  // Stage C
  logic [HMS_W-1:0]     hms_c_r;
  logic [DAY_BITS-1:0]  day_c_r;
  status_t              st_c_r;
  // Stage D
  logic [HMS_W-1:0]     hms_d_r;
  logic [HOUR_W-1:0]    hour_d_r;
  logic [DAY_BITS-1:0]  day_d_r;
  status_t              st_d_r;
  // Stage E
  logic [REM_W-1:0]     rem_e_r;
  logic [HOUR_W-1:0]    hour_e_r;
  logic [DAY_BITS-1:0]  day_e_r;
  status_t              st_e_r;
  // Stage F
  logic [REM_W-1:0]     rem_f_r;
  logic [MIN_W-1:0]     min_f_r;
  logic [HOUR_W-1:0]    hour_f_r;
  logic [DAY_BITS-1:0]  day_f_r;
  status_t              st_f_r;
  // Stage G
  logic [HALF_W-1:0]    half_g_r;
  logic [MIN_W-1:0]     min_g_r;
  logic [HOUR_W-1:0]    hour_g_r;
  logic [DAY_BITS-1:0]  day_g_r;
  status_t              st_g_r;

  logic [DAY_PROD_W-1:0]  day_prod;
  logic [SEC_W-1:0]       day_secs;
  logic [SEC_W-1:0]       hms_full;
  logic                   ovf;
  status_t                st_c_nxt;
  logic [HOUR_PROD_W-1:0] hour_prod;
  logic [HMS_W-1:0]       rem_full;
  logic [MIN_PROD_W-1:0]  min_prod;
  logic [REM_W-1:0]       sec_full;

  always_comb begin
    day_prod = DAY_PROD_W'(off_a_r[31:DAY_PRE_SHIFT]) * DAY_PROD_W'(DAY_RECIP);

    day_secs = SEC_W'(q_b_r) * SEC_W'(SEC_PER_DAY);
    hms_full = {1'b0, off_b_r} - day_secs;
    ovf      = (q_b_r >> DAY_BITS) != '0;
    if (bef_b_r) begin
      st_c_nxt = ST_BEFORE;
    end else if (ovf) begin
      st_c_nxt = ST_OVERFLOW;
    end else begin
      st_c_nxt = ST_OK;
    end

    hour_prod = HOUR_PROD_W'(hms_c_r[HMS_W-1:HOUR_PRE_SHIFT]) * HOUR_PROD_W'(HOUR_RECIP);

    rem_full = hms_d_r - HMS_W'(hour_d_r) * HMS_W'(SEC_PER_HOUR);

    min_prod = MIN_PROD_W'(rem_e_r[REM_W-1:MIN_PRE_SHIFT]) * MIN_PROD_W'(MIN_RECIP);

    sec_full = rem_f_r - REM_W'(min_f_r) * REM_W'(SEC_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_a_r  <= now_seconds - base_seconds;
      bef_a_r  <= now_seconds < base_seconds;

      off_b_r  <= off_a_r;
      bef_b_r  <= bef_a_r;
      q_b_r    <= day_prod[DAY_RECIP_SHIFT +: DAY_Q_W];

      hms_c_r  <= hms_full[HMS_W-1:0];
      day_c_r  <= DAY_BITS'(q_b_r & DAY_Q_W'(DAY_FIELD_MASK));
      st_c_r   <= st_c_nxt;

      hms_d_r  <= hms_c_r;
      hour_d_r <= hour_prod[HOUR_RECIP_SHIFT +: HOUR_W];
      day_d_r  <= day_c_r;
      st_d_r   <= st_c_r;

      rem_e_r  <= rem_full[REM_W-1:0];
      hour_e_r <= hour_d_r;
      day_e_r  <= day_d_r;
      st_e_r   <= st_d_r;

      rem_f_r  <= rem_e_r;
      min_f_r  <= min_prod[MIN_RECIP_SHIFT +: MIN_W];
      hour_f_r <= hour_e_r;
      day_f_r  <= day_e_r;
      st_f_r   <= st_e_r;

      half_g_r <= {sec_full[HALF_W-2:0], 1'b0};
      min_g_r  <= min_f_r;
      hour_g_r <= hour_f_r;
      day_g_r  <= day_f_r;
      st_g_r   <= st_f_r;
    end
  end

  assign status      = st_g_r;
  assign day         = day_g_r;
  assign hour        = hour_g_r;
  assign minute      = min_g_r;
  assign half_second = half_g_r;

endmodule

`default_nettype wire

/* hw/rtl/rsfc_join.sv */
// Join datapath: weights day, hour, minute and seconds, adds the base, and
// delays the sum to the common pipeline depth. Depends on rsfc_pkg.
`default_nettype none

module rsfc_join import rsfc_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [DAY_BITS-1:0] day_in,
  input  wire logic [HOUR_W-1:0]   hour_in,
  input  wire logic [MIN_W-1:0]    minute_in,
  input  wire logic [HALF_W-1:0]   half_second_in,
  input  wire logic [31:0]         base_seconds,
  output logic      [SEC_W-1:0]    seconds
);

  localparam int TAIL = STAGES - 2;

  logic [SEC_W-1:0] day_secs_r;
  logic [HMS_W-1:0] hms_r;
  logic [SEC_W-1:0] sum_r;
  logic [SEC_W-1:0] sec_r [TAIL];

  always_ff @(posedge clk) begin
    if (en) begin
      day_secs_r <= SEC_W'(day_in) * SEC_W'(SEC_PER_DAY);
      hms_r      <= HMS_W'(hour_in) * HMS_W'(SEC_PER_HOUR)
                  + HMS_W'(minute_in) * HMS_W'(SEC_PER_MIN)
                  + HMS_W'(half_second_in[HALF_W-1:1]);
      sum_r      <= day_secs_r + SEC_W'(hms_r);
      sec_r[0]   <= sum_r + SEC_W'(base_seconds);
      for (int i = 1; i < TAIL; i++) begin
        sec_r[i] <= sec_r[i-1];
      end
    end
  end

  assign seconds = sec_r[TAIL-1];

endmodule

`default_nettype wire

/* hw/rtl/rsfc_flow.sv */
// Valid chain of the pipeline and the output skid register that parks a result
// that is not taken; the pipeline freezes while it waits. Depends on rsfc_pkg.
`default_nettype none

module rsfc_flow import rsfc_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   en,
  input  wire logic [DATA_W-1:0] data_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_data
);

  logic              vld_r [STAGES];
  logic              skid_v_r;
  logic [DATA_W-1:0] skid_r;
  logic              vld_last;

  assign vld_last = vld_r[STAGES-1];
  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r[0] <= in_valid;
        for (int i = 1; i < STAGES; i++) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      // The last stage moves on every enabled cycle; a result that is not
      // taken is parked in the skid register and the pipeline freezes.
      if (skid_v_r) begin
        if (out_ready) begin
          skid_v_r <= 1'b0;
        end
      end else if (vld_last && !out_ready) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && vld_last && !out_ready) begin
      skid_r <= data_in;
    end
  end

  assign out_valid = skid_v_r || vld_last;
  assign out_data  = skid_v_r ? skid_r : data_in;

endmodule

`default_nettype wire

/* hw/rtl/rtc_seconds_field_converter_core.sv */
// Real-time-clock converter between absolute seconds and day/hour/minute/
// half-second fields through the seven-stage split pipeline of reciprocal
// multipliers; one item per cycle while no parked result holds the input.
// Reset clears all valid bits and the skid register and loads the base
// seconds with its reset value; there is no clearing pass.
// Depends on rsfc_pkg, rsfc_split, rsfc_join and rsfc_flow.
`default_nettype none

module rtc_seconds_field_converter_core import rsfc_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_base_seconds,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_kind,
  input  wire logic [31:0]         in_now_seconds,
  input  wire logic [DAY_BITS-1:0] in_day_in,
  input  wire logic [HOUR_W-1:0]   in_hour_in,
  input  wire logic [MIN_W-1:0]    in_minute_in,
  input  wire logic [HALF_W-1:0]   in_half_second_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [DAY_BITS-1:0]      out_day_out,
  output logic [HOUR_W-1:0]        out_hour_out,
  output logic [MIN_W-1:0]         out_minute_out,
  output logic [HALF_W-1:0]        out_half_second_out,
  output logic [SEC_W-1:0]         out_seconds_out
);

  localparam int DATA_W = 2 + DAY_BITS + HOUR_W + MIN_W + HALF_W + SEC_W;

  logic [31:0]         base_r;
  logic                en;
  logic                kind_r [STAGES];

  status_t             sp_status;
  logic [DAY_BITS-1:0] sp_day;
  logic [HOUR_W-1:0]   sp_hour;
  logic [MIN_W-1:0]    sp_minute;
  logic [HALF_W-1:0]   sp_half;
  logic [SEC_W-1:0]    jn_seconds;

  logic                sp_ok;
  logic                is_join;
  logic [DATA_W-1:0]   res_data;
  logic [DATA_W-1:0]   out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_valid) begin
      base_r <= cfg_base_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r[0] <= in_kind;
      for (int i = 1; i < STAGES; i++) begin
        kind_r[i] <= kind_r[i-1];
      end
    end
  end

  rsfc_split #(.DAY_BITS(DAY_BITS)) u_split (
    .clk          (clk),
    .en           (en),
    .now_seconds  (in_now_seconds),
    .base_seconds (base_r),
    .status       (sp_status),
    .day          (sp_day),
    .hour         (sp_hour),
    .minute       (sp_minute),
    .half_second  (sp_half)
  );

  rsfc_join #(.DAY_BITS(DAY_BITS)) u_join (
    .clk            (clk),
    .en             (en),
    .day_in         (in_day_in),
    .hour_in        (in_hour_in),
    .minute_in      (in_minute_in),
    .half_second_in (in_half_second_in),
    .base_seconds   (base_r),
    .seconds        (jn_seconds)
  );

  // A split that failed reports only its status; a join reports status OK and seconds.
  always_comb begin
    is_join  = kind_r[STAGES-1];
    sp_ok    = !is_join && (sp_status == ST_OK);
    res_data = {
      is_join ? ST_OK : sp_status,
      sp_ok ? sp_day    : '0,
      sp_ok ? sp_hour   : '0,
      sp_ok ? sp_minute : '0,
      sp_ok ? sp_half   : '0,
      is_join ? jn_seconds : '0
    };
  end

  rsfc_flow #(.DATA_W(DATA_W)) u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .en        (en),
    .data_in   (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign {out_status, out_day_out, out_hour_out, out_minute_out,
          out_half_second_out, out_seconds_out} = out_data;

  // Input is held back only while a parked result waits to be taken.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled without a pending result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without a refused result transfer");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_day_out == '0) && (out_hour_out == '0) && (out_minute_out == '0) &&
      (out_half_second_out == '0) && (out_seconds_out == '0))
    else $error("failed split carries nonzero fields");

endmodule

`default_nettype wire
